>>> rtl/core/assert_macros.svh
// Assertion macros shared by the modular exponentiation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed: always");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same cycle");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");

`endif

>>> rtl/core/mexp_pkg.sv
// Types and constants shared by the modular exponentiation modules.
package mexp_pkg;

  localparam int unsigned MSG_W  = 64;
  localparam int unsigned MOD_W  = 63;
  localparam int unsigned EXP_W  = 64;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned APB_W  = 64;
  localparam int unsigned CNT_W  = 6;

  // Last step index of the message reduction and of one modular product.
  localparam logic [CNT_W-1:0] RED_LAST = CNT_W'(MSG_W - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MOD_W - 1);

  // Register index, taken from paddr[3].
  localparam logic REG_EXPONENT = 1'b0;
  localparam logic REG_MODULUS  = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_STEP_RED,
    OP_FIN_RED,
    OP_PREP,
    OP_STEP_MUL,
    OP_FIN_MUL,
    OP_STEP_SQR,
    OP_FIN_SQR
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_RFIN,
    ST_CHECK,
    ST_MUL,
    ST_MFIN,
    ST_SQR,
    ST_SFIN
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_bit;
  } status_t;

endpackage

>>> rtl/core/mexp_regs.sv
// APB configuration registers: exponent and modulus.
`include "assert_macros.svh"
module mexp_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mexp_pkg::ADDR_W-1:0]  paddr,
  input  logic [mexp_pkg::APB_W-1:0]   pwdata,
  output logic [mexp_pkg::APB_W-1:0]   prdata,
  output logic                         pready,
  output logic [mexp_pkg::EXP_W-1:0]   exponent_o,
  output logic [mexp_pkg::MOD_W-1:0]   modulus_o
);
  import mexp_pkg::*;

  logic             wr_en;
  logic [EXP_W-1:0] exp_q, exp_d;
  logic [MOD_W-1:0] mod_q, mod_d;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    exp_d = exp_q;
    mod_d = mod_q;
    if (wr_en) begin
      case (paddr[3])
        REG_EXPONENT: exp_d = pwdata[EXP_W-1:0];
        REG_MODULUS:  mod_d = pwdata[MOD_W-1:0];
        default:      exp_d = exp_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= EXP_W'(1);
      mod_q <= MOD_W'(1);
    end else begin
      exp_q <= exp_d;
      mod_q <= mod_d;
    end
  end

  always_comb begin
    case (paddr[3])
      REG_EXPONENT: prdata = APB_W'(exp_q);
      REG_MODULUS:  prdata = APB_W'(mod_q);
      default:      prdata = '0;
    endcase
  end

  assign exponent_o = exp_q;
  assign modulus_o  = mod_q;

endmodule

>>> rtl/core/mexp_ctrl.sv
// Sequencer for the reduction, multiply and square passes.
`include "assert_macros.svh"
module mexp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  input  mexp_pkg::status_t status_i,
  output mexp_pkg::cmd_t    cmd_o
);
  import mexp_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RED;
          cnt_d   = RED_LAST;
        end
      end
      ST_RED: begin
        if (cnt_q == '0) state_d = ST_RFIN;
        else cnt_d = cnt_q - CNT_W'(1);
      end
      ST_RFIN: state_d = ST_CHECK;
      ST_CHECK: begin
        cnt_d = MUL_LAST;
        if (status_i.exp_zero) state_d = ST_IDLE;
        else if (status_i.exp_bit) state_d = ST_MUL;
        else state_d = ST_SQR;
      end
      ST_MUL: begin
        if (cnt_q == '0) state_d = ST_MFIN;
        else cnt_d = cnt_q - CNT_W'(1);
      end
      ST_MFIN: state_d = ST_CHECK;
      ST_SQR: begin
        if (cnt_q == '0) state_d = ST_SFIN;
        else cnt_d = cnt_q - CNT_W'(1);
      end
      ST_SFIN: state_d = ST_CHECK;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    done_o   = 1'b0;
    case (state_q)
      ST_IDLE:  cmd_o.op = start ? OP_LOAD : OP_NONE;
      ST_RED:   cmd_o.op = OP_STEP_RED;
      ST_RFIN:  cmd_o.op = OP_FIN_RED;
      ST_CHECK: begin
        // With no exponent bits left the result is final and leaves now.
        if (status_i.exp_zero) done_o = 1'b1;
        else cmd_o.op = OP_PREP;
      end
      ST_MUL:   cmd_o.op = OP_STEP_MUL;
      ST_MFIN:  cmd_o.op = OP_FIN_MUL;
      ST_SQR:   cmd_o.op = OP_STEP_SQR;
      ST_SFIN:  cmd_o.op = OP_FIN_SQR;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `ASSERT_NEXT(a_done_frees, done_o, !busy)
  `ASSERT_NEXT(a_start_takes, start && !busy, busy && !done_o)
  `ASSERT_IMPL(a_done_only_busy, done_o, busy)

endmodule

>>> rtl/core/mexp_dp.sv
// Datapath: shared shift-and-add modular product unit and operand registers.
`include "assert_macros.svh"
module mexp_dp #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mexp_pkg::cmd_t              cmd_i,
  output mexp_pkg::status_t           status_o,
  input  logic [mexp_pkg::MSG_W-1:0]  message_i,
  input  logic [mexp_pkg::EXP_W-1:0]  exponent_i,
  input  logic [mexp_pkg::MOD_W-1:0]  modulus_i,
  output logic [mexp_pkg::MOD_W-1:0]  result_o
);
  import mexp_pkg::*;

  localparam int unsigned SUM_W = MOD_W + 3;

  logic [MOD_W-1:0]      acc_q;
  logic [MOD_W-1:0]      base_q;
  logic [MOD_W-1:0]      res_q;
  logic [MSG_W-1:0]      mplr_q;
  logic [DATA_WIDTH-1:0] exp_q;

  logic [MOD_W-1:0] addend;
  logic [MOD_W-1:0] add_term;
  logic [SUM_W-1:0] sum, sub1, sub2;
  logic [MOD_W-1:0] step_val;

  // One step: 2*acc plus the optional addend lies below 3*m, so one of
  // sum, sum-m or sum-2m is the reduced value.
  always_comb begin
    case (cmd_i.op)
      OP_STEP_RED: addend = MOD_W'(1);
      OP_STEP_MUL: addend = res_q;
      default:     addend = base_q;
    endcase
    add_term = mplr_q[MSG_W-1] ? addend : '0;
    sum  = {2'b00, acc_q, 1'b0} + {3'b000, add_term};
    sub1 = sum - {3'b000, modulus_i};
    sub2 = sum - {2'b00, modulus_i, 1'b0};
    if (!sub2[SUM_W-1])      step_val = sub2[MOD_W-1:0];
    else if (!sub1[SUM_W-1]) step_val = sub1[MOD_W-1:0];
    else                     step_val = sum[MOD_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        acc_q  <= '0;
        mplr_q <= message_i;
        exp_q  <= exponent_i[DATA_WIDTH-1:0];
        res_q  <= (modulus_i == MOD_W'(1)) ? '0 : MOD_W'(1);
      end
      OP_STEP_RED, OP_STEP_MUL, OP_STEP_SQR: begin
        acc_q  <= step_val;
        mplr_q <= {mplr_q[MSG_W-2:0], 1'b0};
      end
      OP_FIN_RED: base_q <= acc_q;
      OP_PREP: begin
        acc_q  <= '0;
        mplr_q <= {base_q, 1'b0};
      end
      OP_FIN_MUL: begin
        res_q    <= acc_q;
        exp_q[0] <= 1'b0;
      end
      OP_FIN_SQR: begin
        base_q <= acc_q;
        exp_q  <= exp_q >> 1;
      end
      default: acc_q <= acc_q;
    endcase
  end

  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.exp_bit  = exp_q[0];

  assign result_o = (modulus_i == '0) ? '0 : res_q;

  `ASSERT_NEXT(a_res_reduced, cmd_i.op == OP_FIN_MUL && modulus_i != '0, res_q < modulus_i)
  `ASSERT_NEXT(a_base_reduced,
      (cmd_i.op == OP_FIN_SQR || cmd_i.op == OP_FIN_RED) && modulus_i != '0,
      base_q < modulus_i)

endmodule

>>> rtl/core/modular_exponentiation_top.sv
// Sequence from the accepting edge to done_o: the message reduction, then one product per
// set exponent bit plus one square per bit position below the highest set bit; each product
// is 63 steps of the single shift-and-add unit plus a setup and a write-back step.
// A new transaction cannot start while one is running; busy stays high through the
// result cycle and the next transaction may start in the cycle after done_o.
// Reset is asynchronous, active low; exponent and modulus reset to one; no receiver stall.
module modular_exponentiation_top #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [mexp_pkg::MSG_W-1:0]  message_i,
  output logic                        done_o,
  output logic [mexp_pkg::MOD_W-1:0]  result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mexp_pkg::ADDR_W-1:0] paddr,
  input  logic [mexp_pkg::APB_W-1:0]  pwdata,
  output logic [mexp_pkg::APB_W-1:0]  prdata,
  output logic                        pready
);
  import mexp_pkg::*;

  logic [EXP_W-1:0] exponent;
  logic [MOD_W-1:0] modulus;
  cmd_t             cmd;
  status_t          status;

  mexp_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .exponent_o (exponent),
    .modulus_o  (modulus)
  );

  mexp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  mexp_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .message_i  (message_i),
    .exponent_i (exponent),
    .modulus_i  (modulus),
    .result_o   (result_o)
  );

endmodule
